// File: sv/fexp_pkg.sv
package fexp_pkg;

	// table resolution: entries per unit of the reduced argument
	localparam int STEPS_PER_UNIT = 256;
	localparam int ROM_HALF = (STEPS_PER_UNIT * 3) / 8 + 1;
	localparam int JW = $clog2(ROM_HALF + 1);
	localparam int TW = $clog2((2 ** 30) / STEPS_PER_UNIT + 1);

	localparam logic [31:0] X_LOW_BITS  = 32'h3F80_0000;
	localparam logic [31:0] X_HIGH_BITS = 32'h42B1_7218;
	localparam logic [32:0] INV_LN2_Q32 = 33'h1_7154_7653;
	// ln2 high part plus low part, q40
	localparam logic [39:0] LN2_Q40 = 40'hB1_7200_0000 + 40'h00_0017_F7D2;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [31:0] SAT_BITS = 32'h7F7F_FFFF;

	typedef logic [ROM_HALF:0][23:0] rom_t;

	// stage 4 to stage 5 hand-off
	typedef struct packed {
		logic          valid;
		logic          oor;
		logic          neg;
		logic [JW-1:0] jm;
		logic [TW-1:0] tm;
		logic [7:0]    k;
	} red_t;

	// stage 6 to stage 7 hand-off
	typedef struct packed {
		logic        valid;
		logic        oor;
		logic [7:0]  k;
		logic [55:0] prod;
	} prd_t;

	// exp(+-mag/steps) in q23, taylor series in q60, evaluated at elaboration
	function automatic logic [23:0] rom_calc(int mag, bit neg);
		logic [63:0]  q;
		logic [63:0]  rem;
		logic [63:0]  y;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [127:0] pr;
		q = (64'(mag) << 52) / STEPS_PER_UNIT;
		rem = (64'(mag) << 52) % STEPS_PER_UNIT;
		y = (q << 8) + ((rem << 8) / STEPS_PER_UNIT);
		term = 64'd1 << 60;
		sum = 64'd1 << 60;
		for (int n = 1; n <= 24; n++) begin
			pr = 128'(term) * 128'(y);
			term = pr[123:60] / 64'(n);
			if (neg && (n % 2 == 1))
				sum = sum - term;
			else
				sum = sum + term;
		end
		return 24'((sum + (64'd1 << 36)) >> 37);
	endfunction

	function automatic rom_t rom_build(bit neg);
		rom_t r;
		for (int i = 0; i <= ROM_HALF; i++)
			r[i] = rom_calc(i, neg);
		return r;
	endfunction

	localparam rom_t ROM_POS = rom_build(1'b0);
	localparam rom_t ROM_NEG = rom_build(1'b1);

endpackage

// File: sv/float_exp_positive_kernel.sv
// throughput: one transaction per cycle while the master side accepts or the output
// register is empty; the product multiplier and the rounding shifter are each a stage
// of their own, and the whole pipe advances together
// a stall on the master side freezes every stage, so nothing is lost or repeated
// reset: arst_n asynchronous active low clears every stage valid bit; data is not reset
module float_exp_positive_kernel (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: argument
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] x_bits
	// master side: result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_bits
	output logic        m_tuser    // [0] out_of_range
);
	import fexp_pkg::*;

	// pipe advances whenever the output register is empty or being drained
	logic   en;
	red_t   red;
	prd_t   prd;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stages 1-4: decode, k = round(x/ln2), r = x - k*ln2, split r into j and t
	fexp_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.x_bits   (s_tdata),
		.red      (red)
	);

	// stages 5-6: p = 1 +- t + t*t/2 by the sign, table lookup of exp(+-j/steps), product
	fexp_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.red    (red),
		.prd    (prd)
	);

	// stages 7-8: leading one, round to nearest even, exponent, output register
	fexp_norm u_norm (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.prd          (prd),
		.valid        (m_tvalid),
		.result_bits  (m_tdata),
		.out_of_range (m_tuser)
	);

`ifndef SYNTHESIS
	// out of range results carry zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("out of range result not zero");

	// in range results are positive and normal
	a_pos_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[31] && m_tdata[30:23] != 8'd0
			&& m_tdata[30:23] != 8'hFF)
		else $error("in range result not a positive normal");

	// a stalled pipe holds its stage 6 to stage 7 hand-off
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(prd))
		else $error("pipe moved during stall");
`endif

endmodule

// File: sv/fexp_reduce.sv
module fexp_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         x_bits,
	output fexp_pkg::red_t      red
);
	import fexp_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        oor_s1, oor_s2, oor_s3;
	logic [30:0] xfix_s1, xfix_s2;
	logic [7:0]  k_s2, k_s3;
	logic        neg_s3;
	logic [30:0] rmag_s3;
	red_t        red_s4;

	logic        oor_c;
	logic [7:0]  e_c;
	logic [3:0]  sh_c;
	logic [63:0] kprod_c;
	logic [47:0] a_c, b_c, mag_c;
	logic [47:0] rnd_c;
	logic [40:0] prod_c;
	logic [40:0] jm_c;
	logic [29:0] tm_c;

	always_comb begin
		oor_c = (x_bits <= X_LOW_BITS) || (x_bits >= X_HIGH_BITS);
		e_c = x_bits[30:23] - 8'd127;
		sh_c = {1'b0, e_c[2:0]} + 4'd1;
		kprod_c = 64'(xfix_s1) * 64'(INV_LN2_Q32) + (64'd1 << 55);
		a_c = 48'(xfix_s2) << 16;
		b_c = 48'(k_s2) * 48'(LN2_Q40);
		mag_c = (a_c < b_c) ? (b_c - a_c) : (a_c - b_c);
		rnd_c = (mag_c + 48'd512) >> 10;
		prod_c = 41'(rmag_s3) * 41'(STEPS_PER_UNIT);
		jm_c = prod_c >> 30;
		tm_c = 30'(prod_c[29:0] / STEPS_PER_UNIT);
		if (jm_c > 41'(ROM_HALF))
			jm_c = 41'(ROM_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// decode to q24
			oor_s1 <= oor_c;
			xfix_s1 <= 31'({1'b1, x_bits[22:0]}) << sh_c;
			// nearest multiple of ln2
			oor_s2 <= oor_s1;
			xfix_s2 <= xfix_s1;
			k_s2 <= kprod_c[63:56];
			// reduced argument, sign and magnitude q30
			oor_s3 <= oor_s2;
			k_s3 <= k_s2;
			neg_s3 <= a_c < b_c;
			rmag_s3 <= rnd_c[30:0];
			// table index and remainder
			red_s4.oor <= oor_s3;
			red_s4.neg <= neg_s3;
			red_s4.k <= k_s3;
			red_s4.jm <= jm_c[JW-1:0];
			red_s4.tm <= tm_c[TW-1:0];
		end
	end

	always_comb begin
		red.valid = v_s4;
		red.oor = red_s4.oor;
		red.neg = red_s4.neg;
		red.jm = red_s4.jm;
		red.tm = red_s4.tm;
		red.k = red_s4.k;
	end

endmodule

// File: sv/fexp_poly.sv
module fexp_poly (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fexp_pkg::red_t  red,
	output fexp_pkg::prd_t  prd
);
	import fexp_pkg::*;

	logic        v_s5, v_s6;
	logic        oor_s5, oor_s6;
	logic [7:0]  k_s5, k_s6;
	logic [31:0] p_s5;
	logic [23:0] rom_s5;
	logic [55:0] prod_s6;

	logic [2*TW:0] sq_c;
	logic [31:0]   t2_c;
	logic [31:0]   p_c;

	always_comb begin
		sq_c = (2*TW+1)'(red.tm) * (2*TW+1)'(red.tm) + (2*TW+1)'(ONE_Q30);
		t2_c = 32'(sq_c >> 31);
		if (red.neg)
			p_c = ONE_Q30 - 32'(red.tm) + t2_c;
		else
			p_c = ONE_Q30 + 32'(red.tm) + t2_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= red.valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s5 <= red.oor;
			k_s5 <= red.k;
			p_s5 <= p_c;
			rom_s5 <= red.neg ? ROM_NEG[red.jm] : ROM_POS[red.jm];
			oor_s6 <= oor_s5;
			k_s6 <= k_s5;
			prod_s6 <= 56'(p_s5) * 56'(rom_s5);
		end
	end

	always_comb begin
		prd.valid = v_s6;
		prd.oor = oor_s6;
		prd.k = k_s6;
		prd.prod = prod_s6;
	end

endmodule

// File: sv/fexp_norm.sv
module fexp_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fexp_pkg::prd_t  prd,
	output logic            valid,
	output logic [31:0]     result_bits,
	output logic            out_of_range
);
	import fexp_pkg::*;

	logic        v_s7;
	logic        oor_s7;
	logic [7:0]  k_s7;
	logic [55:0] prod_s7;
	logic [5:0]  lead_s7;
	logic        valid_q;
	logic [31:0] result_q;
	logic        oor_q;

	logic [5:0]         lead_c;
	logic [5:0]         sh_c;
	logic [55:0]        mant_c;
	logic [55:0]        rb_c;
	logic [55:0]        half_c;
	logic signed [10:0] biased_c;
	logic [31:0]        res_c;

	// leading one position
	always_comb begin
		lead_c = '0;
		for (int i = 0; i < 56; i++)
			if (prd.prod[i])
				lead_c = 6'(i);
	end

	// round to 24 bits, ties to even, then pack; saturate on overflow, zero on underflow or out of range
	always_comb begin
		sh_c = lead_s7 - 6'd23;
		rb_c = '0;
		half_c = '0;
		if (lead_s7 > 6'd23) begin
			mant_c = prod_s7 >> sh_c;
			rb_c = prod_s7 & ((56'd1 << sh_c) - 56'd1);
			half_c = 56'd1 << (sh_c - 6'd1);
			if (rb_c > half_c || (rb_c == half_c && mant_c[0]))
				mant_c = mant_c + 56'd1;
		end else begin
			mant_c = prod_s7 << (6'd23 - lead_s7);
		end
		biased_c = 11'sd127 + $signed({3'b000, k_s7}) + $signed({5'b00000, lead_s7})
			- 11'sd53;
		if (mant_c[24]) begin
			mant_c = mant_c >> 1;
			biased_c = biased_c + 11'sd1;
		end
		if (oor_s7)
			res_c = '0;
		else if (biased_c > 11'sd254)
			res_c = SAT_BITS;
		else if (biased_c < 11'sd1)
			res_c = '0;
		else
			res_c = {1'b0, biased_c[7:0], mant_c[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s7 <= prd.valid;
			valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s7 <= prd.oor;
			k_s7 <= prd.k;
			prod_s7 <= prd.prod;
			lead_s7 <= lead_c;
			result_q <= res_c;
			oor_q <= oor_s7;
		end
	end

	assign valid = valid_q;
	assign result_bits = result_q;
	assign out_of_range = oor_q;

endmodule
